// ===== hw/rtl/contiguous_page_bitmap_allocator_assert.svh =====
// ----------------------------------------------------------------------------
// Page allocator assertion macros
// Short forms for clocked implications used by the allocator checks.
// ----------------------------------------------------------------------------
`ifndef CONTIGUOUS_PAGE_BITMAP_ALLOCATOR_ASSERT_SVH
`define CONTIGUOUS_PAGE_BITMAP_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, disabled in reset
`define CPBA_ASSERT_NOW(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset
`define CPBA_ASSERT_NEXT(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/cpba_pkg.sv =====
// ----------------------------------------------------------------------------
// Page allocator package
// Shared types, codes and the per-word run search.
// ----------------------------------------------------------------------------
package cpba_pkg;

  localparam int MAP_COUNT_DEF     = 16;
  localparam int PAGES_PER_MAP_DEF = 4096;
  localparam int WORD_BITS         = 32;
  localparam int RUN_W             = 17;

  localparam logic [15:0] PAGE_BYTES_RST = 16'd4096;

  localparam logic [1:0] FN_ALLOC = 2'd0;
  localparam logic [1:0] FN_FREE  = 2'd1;
  localparam logic [1:0] FN_QUERY = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOSPACE = 2'd1;
  localparam logic [1:0] ST_BADARG  = 2'd2;

  typedef struct packed {
    logic [1:0]  func;
    logic [3:0]  map_index;
    logic [15:0] page_index;
    logic [31:0] size_bytes;
  } req_t;

  typedef struct packed {
    logic [19:0] handle;
    logic        is_allocated;
    logic [1:0]  status;
  } rsp_t;

  typedef struct packed {
    logic             found;
    logic [4:0]       idx;
    logic [RUN_W-1:0] carry;
  } scan_t;

  // Find the first bit that ends a clear run of length n, given the run
  // carried in from earlier words; blk marks pages that cannot be used.
  function automatic scan_t scan_word(logic [WORD_BITS-1:0] blk,
                                      logic [RUN_W-1:0] carry,
                                      logic [RUN_W-1:0] n);
    scan_t            res;
    logic [RUN_W-1:0] run;
    logic             hit;
    res = '0;
    hit = 1'b0;
    run = '0;
    for (int j = 0; j < WORD_BITS; j++) begin
      run = carry + RUN_W'(j + 1);
      for (int k = 0; k <= j; k++) begin
        if (blk[k]) begin
          run = RUN_W'(j - k);
        end
      end
      if (!hit && run >= n) begin
        hit     = 1'b1;
        res.idx = 5'(j);
      end
    end
    res.found = hit;
    res.carry = run;
    return res;
  endfunction

endpackage

// ===== hw/rtl/contiguous_page_bitmap_allocator.sv =====
// ----------------------------------------------------------------------------
// Contiguous page bitmap allocator
// First-fit allocation of page runs over bitmaps kept in one word memory.
// ----------------------------------------------------------------------------
// After reset the block sweeps its bitmap memory clear, one 32-page word per
// cycle, MAP_COUNT * ceil(PAGES_PER_MAP/32) words (2048 at the defaults),
// and holds req_stall high meanwhile. It then takes one request at a time and
// stalls until the response has been taken. Allocate and free first run the
// divider to turn bytes into pages. An allocate then scans each map in use one
// 32-page word at a time, from the map's cached start word to its end, and
// writes the found run back word by word; a free only does the write-back. On
// the single memory port each word is read, then evaluated or written.
module contiguous_page_bitmap_allocator #(
  parameter int MAP_COUNT     = cpba_pkg::MAP_COUNT_DEF,
  parameter int PAGES_PER_MAP = cpba_pkg::PAGES_PER_MAP_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  cpba_pkg::req_t       req,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output cpba_pkg::rsp_t       rsp,
  input  logic                 cfg_we,
  input  logic [15:0]          cfg_wdata
);
  import cpba_pkg::*;
  `include "contiguous_page_bitmap_allocator_assert.svh"

  localparam int WPM   = (PAGES_PER_MAP + WORD_BITS - 1) / WORD_BITS;
  localparam int DEPTH = MAP_COUNT * WPM;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int WW    = (WPM > 1) ? $clog2(WPM) : 1;
  localparam int MW    = (MAP_COUNT > 1) ? $clog2(MAP_COUNT) : 1;
  localparam int MUW   = $clog2(MAP_COUNT + 1);
  localparam int PW    = $clog2(PAGES_PER_MAP);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_DIV, S_MAP, S_SRD, S_SEV, S_MRD, S_MWR, S_QRD, S_QEV, S_DONE
  } state_t;

  state_t           state;
  logic [AW-1:0]    clr_addr;
  logic [15:0]      page_bytes;
  logic [1:0]       op;
  logic [15:0]      pi_r;
  logic [31:0]      size_r;
  logic [RUN_W-1:0] n_r;
  logic [MUW-1:0]   cur_m;
  logic [WW-1:0]    cur_w;
  logic [RUN_W-1:0] carry;
  logic [RUN_W-1:0] start_r;
  logic [RUN_W-1:0] lo;
  logic [RUN_W-1:0] hi;
  logic [MUW-1:0]   maps_in_use;
  logic [PW-1:0]    search_start [MAP_COUNT];
  logic             div_start;

  logic             div_done;
  logic [31:0]      div_quot;
  logic [15:0]      div_rem;
  logic [32:0]      n_full;

  logic             ram_we;
  logic [AW-1:0]    ram_addr;
  logic [31:0]      ram_wdata;
  logic [31:0]      ram_rdata;

  logic [RUN_W-1:0] wbase;
  logic [31:0]      blk;
  logic [31:0]      rng;
  scan_t            scan;
  logic             accept;
  logic             bad_place;
  logic [RUN_W-1:0] map_start;
  logic [RUN_W-1:0] found_pos;
  logic [RUN_W-1:0] hi_next;

  cpba_div u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (size_r),
    .den  (page_bytes),
    .done (div_done),
    .quot (div_quot),
    .rem  (div_rem)
  );

  cpba_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  assign accept    = req_valid && !req_stall;
  assign req_stall = (state != S_IDLE);
  assign n_full    = {1'b0, div_quot} + 33'(div_rem != 16'd0);
  assign bad_place = ({1'b0, req.map_index} >= 5'(maps_in_use)) ||
                     (req.page_index == 16'd0) ||
                     (17'(req.page_index) >= 17'(PAGES_PER_MAP));

  // Address the current word; the clear sweep owns the port after reset
  assign ram_addr  = (state == S_CLR) ? clr_addr :
                     AW'(32'(cur_m) * WPM + 32'(cur_w));
  assign ram_we    = (state == S_CLR) || (state == S_MWR);
  assign ram_wdata = (state == S_CLR) ? 32'd0 :
                     (op == FN_ALLOC) ? (ram_rdata | rng) : (ram_rdata & ~rng);

  // Mark pages that a run may not use, and pages inside the target range
  assign wbase = RUN_W'(cur_w) << 5;
  always_comb begin
    for (int b = 0; b < WORD_BITS; b++) begin
      blk[b] = ram_rdata[b] || ((wbase + RUN_W'(b)) < start_r) ||
               ((wbase + RUN_W'(b)) == '0) ||
               ((wbase + RUN_W'(b)) >= RUN_W'(PAGES_PER_MAP));
      rng[b] = ((wbase + RUN_W'(b)) >= lo) && ((wbase + RUN_W'(b)) <= hi);
    end
  end

  assign scan      = scan_word(blk, carry, n_r);
  assign found_pos = wbase + RUN_W'(scan.idx) + RUN_W'(1) - n_r;
  assign map_start = (n_r > RUN_W'(1)) ? RUN_W'(search_start[cur_m[MW-1:0]])
                                       : RUN_W'(1);
  assign hi_next   = hi + RUN_W'(1);

  // Sequence requests over the divider and the bitmap memory
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLR;
      clr_addr    <= '0;
      page_bytes  <= PAGE_BYTES_RST;
      maps_in_use <= MUW'(1);
      rsp_valid   <= 1'b0;
      div_start   <= 1'b0;
      for (int i = 0; i < MAP_COUNT; i++) begin
        search_start[i] <= PW'(1);
      end
    end else begin
      div_start <= 1'b0;
      if (cfg_we) begin
        page_bytes <= cfg_wdata;
      end
      unique case (state)
        S_CLR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            op                <= req.func;
            pi_r              <= req.page_index;
            size_r            <= req.size_bytes;
            cur_m             <= MUW'(req.map_index);
            cur_w             <= WW'(req.page_index >> 5);
            rsp.handle        <= '0;
            rsp.is_allocated  <= 1'b0;
            rsp.status        <= ST_OK;
            unique case (req.func)
              FN_ALLOC: begin
                if (page_bytes == 16'd0 || req.size_bytes == 32'd0) begin
                  rsp.status <= ST_BADARG;
                  rsp_valid  <= 1'b1;
                  state      <= S_DONE;
                end else begin
                  div_start <= 1'b1;
                  state     <= S_DIV;
                end
              end
              FN_FREE: begin
                if (page_bytes == 16'd0 || bad_place) begin
                  rsp.status <= ST_BADARG;
                  rsp_valid  <= 1'b1;
                  state      <= S_DONE;
                end else begin
                  div_start <= 1'b1;
                  state     <= S_DIV;
                end
              end
              FN_QUERY: begin
                if (bad_place) begin
                  rsp.status <= ST_BADARG;
                  rsp_valid  <= 1'b1;
                  state      <= S_DONE;
                end else begin
                  state <= S_QRD;
                end
              end
              default: begin
                rsp.status <= ST_BADARG;
                rsp_valid  <= 1'b1;
                state      <= S_DONE;
              end
            endcase
          end
        end
        S_DIV: begin
          if (div_done) begin
            n_r <= RUN_W'(n_full);
            if (op == FN_ALLOC) begin
              if (n_full > 33'(PAGES_PER_MAP - 1)) begin
                rsp.status <= ST_NOSPACE;
                rsp_valid  <= 1'b1;
                state      <= S_DONE;
              end else begin
                cur_m <= '0;
                state <= S_MAP;
              end
            end else if ((34'(pi_r) + 34'(n_full)) > 34'(PAGES_PER_MAP)) begin
              rsp.status <= ST_BADARG;
              rsp_valid  <= 1'b1;
              state      <= S_DONE;
            end else if (n_full == 33'd0) begin
              search_start[cur_m[MW-1:0]] <= PW'(pi_r);
              rsp_valid <= 1'b1;
              state     <= S_DONE;
            end else begin
              lo    <= RUN_W'(pi_r);
              hi    <= RUN_W'(pi_r) + RUN_W'(n_full) - RUN_W'(1);
              state <= S_MRD;
            end
          end
        end
        S_MAP: begin
          if (cur_m < maps_in_use) begin
            start_r <= map_start;
            cur_w   <= WW'(map_start >> 5);
            carry   <= '0;
            state   <= S_SRD;
          end else if (maps_in_use < MUW'(MAP_COUNT)) begin
            // Append a fresh map; it is still clear from the reset sweep
            cur_m       <= maps_in_use;
            maps_in_use <= maps_in_use + MUW'(1);
            cur_w       <= '0;
            lo          <= RUN_W'(1);
            hi          <= n_r;
            state       <= S_MRD;
          end else begin
            rsp.status <= ST_NOSPACE;
            rsp_valid  <= 1'b1;
            state      <= S_DONE;
          end
        end
        S_SRD: begin
          state <= S_SEV;
        end
        S_SEV: begin
          if (scan.found) begin
            lo    <= found_pos;
            hi    <= wbase + RUN_W'(scan.idx);
            cur_w <= WW'(found_pos >> 5);
            state <= S_MRD;
          end else if (cur_w == WW'(WPM - 1)) begin
            cur_m <= cur_m + MUW'(1);
            state <= S_MAP;
          end else begin
            carry <= scan.carry;
            cur_w <= cur_w + WW'(1);
            state <= S_SRD;
          end
        end
        S_MRD: begin
          state <= S_MWR;
        end
        S_MWR: begin
          if (cur_w == WW'(hi >> 5)) begin
            if (op == FN_ALLOC) begin
              search_start[cur_m[MW-1:0]] <=
                (hi_next == RUN_W'(PAGES_PER_MAP)) ? '0 : PW'(hi_next);
              rsp.handle <= {4'(cur_m), 16'(lo)};
            end else begin
              search_start[cur_m[MW-1:0]] <= PW'(pi_r);
            end
            rsp_valid <= 1'b1;
            state     <= S_DONE;
          end else begin
            cur_w <= cur_w + WW'(1);
            state <= S_MRD;
          end
        end
        S_QRD: begin
          state <= S_QEV;
        end
        S_QEV: begin
          rsp.is_allocated <= ram_rdata[pi_r[4:0]];
          rsp_valid        <= 1'b1;
          state            <= S_DONE;
        end
        S_DONE: begin
          if (!rsp_stall) begin
            rsp_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Checks on the sequencer
  `CPBA_ASSERT_NOW(a_rsp_blocks_req, rsp_valid, req_stall, "request taken with response pending")
  `CPBA_ASSERT_NOW(a_maps_range, 1'b1, (maps_in_use >= MUW'(1)) && (maps_in_use <= MUW'(MAP_COUNT)), "map count out of range")
  `CPBA_ASSERT_NOW(a_alloc_page, rsp_valid && op == FN_ALLOC && rsp.status == ST_OK, rsp.handle[15:0] != 16'd0, "allocation on reserved page")
  `CPBA_ASSERT_NEXT(a_busy_after_req, accept, req_stall, "block ready right after a request")
endmodule

// ===== hw/rtl/cpba_div.sv =====
// ----------------------------------------------------------------------------
// Page allocator divider
// Restoring divider, one quotient bit per cycle, for byte-to-page rounding.
// ----------------------------------------------------------------------------
module cpba_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] num,
  input  logic [15:0] den,
  output logic        done,
  output logic [31:0] quot,
  output logic [15:0] rem
);
  logic        busy;
  logic [5:0]  cnt;
  logic [16:0] shifted;
  logic [16:0] trial;

  // Shift in the next dividend bit and try a subtract
  assign shifted = {rem, quot[31]};
  assign trial   = shifted - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'd32;
        quot <= num;
        rem  <= '0;
      end else if (busy) begin
        if (shifted >= {1'b0, den}) begin
          rem  <= trial[15:0];
          quot <= {quot[30:0], 1'b1};
        end else begin
          rem  <= shifted[15:0];
          quot <= {quot[30:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// ===== hw/rtl/cpba_ram.sv =====
// ----------------------------------------------------------------------------
// Page allocator bitmap memory
// Single-port word memory with registered read data.
// ----------------------------------------------------------------------------
module cpba_ram #(
  parameter int DEPTH = 2048,
  parameter int AW    = 11
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [31:0]   wdata,
  output logic [31:0]   rdata
);
  logic [31:0] mem [DEPTH];

  // Write and read one word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ===== tb/sv/cpba_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page allocator response checker
// Watches the request, response and register ports, keeps its own copy of
// the page bitmaps, and compares every response with the predicted one.
// ----------------------------------------------------------------------------
module cpba_checker #(
  parameter int MAPS  = 16,
  parameter int PAGES = 4096
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  input  logic           req_stall,
  input  cpba_pkg::req_t req,
  input  logic           rsp_valid,
  input  logic           rsp_stall,
  input  cpba_pkg::rsp_t rsp,
  input  logic           cfg_we,
  input  logic [15:0]    cfg_wdata,
  output int             fail_count,
  output int             pending,
  output int             compared
);
  import cpba_pkg::*;

  bit          page_map [MAPS][PAGES];
  int unsigned maps_used;
  int unsigned start_pos [MAPS];
  logic [15:0] page_sz;
  rsp_t        expected_rsp [$];

  // Clear all maps to the reset picture
  task automatic clear_maps();
    for (int m = 0; m < MAPS; m++) begin
      for (int p = 0; p < PAGES; p++) page_map[m][p] = 1'b0;
      start_pos[m] = 1;
    end
    page_map[0][0] = 1'b1;
    maps_used = 1;
    page_sz = PAGE_BYTES_RST;
  endtask

  // Work out the response to one request and update the bitmaps
  function automatic rsp_t predict_allocation(req_t r);
    rsp_t              o;
    longint unsigned   n64;
    int unsigned       n, m, pos, k;
    bit                hit;
    o = '0;
    o.status = ST_OK;
    hit = 1'b0;
    pos = 0;
    m = 0;
    if (r.func == FN_ALLOC) begin
      if (page_sz == 0 || r.size_bytes == 0) begin
        o.status = ST_BADARG;
      end else begin
        n64 = (longint'(r.size_bytes) + page_sz - 1) / page_sz;
        if (n64 > PAGES - 1) begin
          o.status = ST_NOSPACE;
        end else begin
          n = 32'(n64);
          // first fit over the maps in use
          for (m = 0; m < maps_used; m++) begin
            pos = (n > 1) ? start_pos[m] : 1;
            while (1) begin
              while (pos < PAGES && page_map[m][pos]) pos++;
              if (pos >= PAGES) break;
              k = 0;
              while (k < n && pos + k < PAGES && !page_map[m][pos + k]) k++;
              if (k == n) begin
                hit = 1'b1;
                break;
              end
              pos += k + 1;
            end
            if (hit) break;
          end
          // append a fresh map when nothing fits
          if (!hit) begin
            if (maps_used < MAPS) begin
              m = maps_used;
              for (int p = 0; p < PAGES; p++) page_map[m][p] = 1'b0;
              page_map[m][0] = 1'b1;
              maps_used++;
              pos = 1;
              hit = 1'b1;
            end else begin
              o.status = ST_NOSPACE;
            end
          end
          if (hit) begin
            for (int j = 0; j < n; j++) page_map[m][pos + j] = 1'b1;
            start_pos[m] = (pos + n) % PAGES;
            o.handle = {m[3:0], pos[15:0]};
          end
        end
      end
    end else if (r.func == FN_FREE) begin
      if (page_sz == 0 || r.map_index >= maps_used || r.page_index == 0 ||
          r.page_index >= PAGES) begin
        o.status = ST_BADARG;
      end else begin
        n64 = (longint'(r.size_bytes) + page_sz - 1) / page_sz;
        if (longint'(r.page_index) + n64 > PAGES) begin
          o.status = ST_BADARG;
        end else begin
          for (int j = 0; j < n64; j++) page_map[r.map_index][r.page_index + j] = 1'b0;
          start_pos[r.map_index] = 32'(r.page_index);
        end
      end
    end else if (r.func == FN_QUERY) begin
      if (r.map_index >= maps_used || r.page_index == 0 || r.page_index >= PAGES)
        o.status = ST_BADARG;
      else
        o.is_allocated = page_map[r.map_index][r.page_index];
    end else begin
      o.status = ST_BADARG;
    end
    return o;
  endfunction

  // Compare responses first, then predict new requests, then register writes
  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      clear_maps();
      expected_rsp.delete();
      fail_count = 0;
      compared = 0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (expected_rsp.size() == 0) begin
          $error("response with no request outstanding: %h", rsp);
          fail_count++;
        end else begin
          want = expected_rsp.pop_front();
          compared++;
          if (rsp.handle !== want.handle) begin
            $error("handle: expected %h, got %h", want.handle, rsp.handle);
            fail_count++;
          end
          if (rsp.is_allocated !== want.is_allocated) begin
            $error("is_allocated: expected %b, got %b", want.is_allocated,
                   rsp.is_allocated);
            fail_count++;
          end
          if (rsp.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp.status);
            fail_count++;
          end
        end
      end
      if (req_valid && !req_stall) expected_rsp.push_back(predict_allocation(req));
      if (cfg_we) page_sz = cfg_wdata;
    end
    pending = expected_rsp.size();
  end

endmodule

// ===== tb/sv/tb_contiguous_page_bitmap_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page allocator testbench
// Drives allocate, free and query requests over several page sizes, with
// random gaps and response stalls; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_contiguous_page_bitmap_allocator;
  import cpba_pkg::*;

  localparam logic [1:0] FN_UNKNOWN = 2'd3;
  localparam int         PAGES      = 4096;
  localparam int         IDLE_LIMIT = 100000;

  logic        clk;
  logic        rst;
  logic        req_valid;
  logic        req_stall;
  req_t        req;
  logic        rsp_valid;
  logic        rsp_stall;
  rsp_t        rsp;
  logic        cfg_we;
  logic [15:0] cfg_wdata;
  int          fail_count;
  int          pending;
  int          compared;

  logic [15:0] cur_page_sz;
  bit          no_idle;
  int          sent;
  int          idle_cycles;
  logic [19:0] live_handles [$];

  contiguous_page_bitmap_allocator dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  cpba_checker chk (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req        (req),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .rsp        (rsp),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending),
    .compared   (compared)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Random response stalls, off during the quiet stretch
  always @(negedge clk) begin
    rsp_stall <= no_idle ? 1'b0 : ($urandom_range(0, 99) < 12);
  end

  // Remember handles of good allocations for later frees and queries
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall && rsp.status == ST_OK && rsp.handle != 0)
      live_handles.push_back(rsp.handle);
    if (live_handles.size() > 64) live_handles.pop_front();
  end

  // Watchdog on cycles with no handshake
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_contiguous_page_bitmap_allocator: errors");
      $finish;
    end
  end

  // Present one request and hold it until it is taken
  task automatic send(logic [1:0] fn, logic [3:0] mi, logic [15:0] pi, logic [31:0] sz);
    if (!no_idle && $urandom_range(0, 99) < 12) begin
      req_valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    req_valid = 1'b1;
    req.func = fn;
    req.map_index = mi;
    req.page_index = pi;
    req.size_bytes = sz;
    do @(posedge clk); while (req_stall);
    @(negedge clk);
    req_valid = 1'b0;
    sent++;
  endtask

  // Byte count that rounds up to the given number of pages
  function automatic logic [31:0] bytes_for(int unsigned pages);
    longint unsigned b;
    if (cur_page_sz == 0) return $urandom;
    b = longint'(pages) * cur_page_sz - $urandom_range(0, cur_page_sz - 1);
    return b[31:0];
  endfunction

  // Drain outstanding responses, then write the page size
  task automatic set_page_size(logic [15:0] v);
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 1'b0;
    cur_page_sz = v;
  endtask

  // One random request, mostly well formed
  task automatic random_request();
    int unsigned sel, pages;
    logic [19:0] h;
    sel = $urandom_range(0, 99);
    pages = ($urandom_range(0, 19) == 0) ? $urandom_range(1, PAGES - 1) : $urandom_range(1, 40);
    h = (live_handles.size() != 0) ?
        live_handles[$urandom_range(0, live_handles.size() - 1)] : 20'h00001;
    if (sel < 35)
      send(FN_ALLOC, 4'($urandom), 16'($urandom), bytes_for(pages));
    else if (sel < 60)
      send(FN_FREE, h[19:16], h[15:0] + 16'($urandom_range(0, 2)),
           bytes_for($urandom_range(1, 40)));
    else if (sel < 90)
      send(FN_QUERY, h[19:16], h[15:0] + 16'($urandom_range(0, 3)), $urandom);
    else
      send(2'($urandom), 4'($urandom), 16'($urandom), $urandom);
  endtask

  initial begin
    logic [15:0] sizes [5];
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    cur_page_sz = PAGE_BYTES_RST;
    no_idle = 1'b0;
    sent = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: zero size, single page, runs too long, full-map run, then queries, frees and an unknown code
    send(FN_ALLOC, 4'h0, 16'h0000, 32'h0000_0000);
    send(FN_ALLOC, 4'h0, 16'h0000, 32'h0000_0001);
    send(FN_ALLOC, 4'h0, 16'h0000, 32'hFFFF_FFFF);
    send(FN_ALLOC, 4'h0, 16'h0000, 32'd4096 * 4095 + 1);
    send(FN_ALLOC, 4'h0, 16'h0000, 32'd4096 * 4095);
    send(FN_QUERY, 4'h1, 16'd4095, 32'h0);
    send(FN_QUERY, 4'h0, 16'h0000, 32'h0);
    send(FN_QUERY, 4'h0, 16'd4096, 32'h0);
    send(FN_QUERY, 4'h0, 16'hFFFF, 32'hFFFF_FFFF);
    send(FN_QUERY, 4'hF, 16'h0001, 32'h0);
    send(FN_FREE, 4'h1, 16'd4095, 32'd4097);
    send(FN_FREE, 4'h1, 16'd4095, 32'd1);
    send(FN_QUERY, 4'h1, 16'd4095, 32'h0);
    send(FN_FREE, 4'h1, 16'd4095, 32'd1);
    send(FN_FREE, 4'h0, 16'd5, 32'd0);
    send(FN_UNKNOWN, 4'hF, 16'hFFFF, 32'hFFFF_FFFF);

    // Fill maps 2 to 15, hit the all-full case, then release maps 1 to 15 again
    for (int m = 0; m < 15; m++) send(FN_ALLOC, 4'h0, 16'h0, 32'd4096 * 4095);
    send(FN_ALLOC, 4'h0, 16'h0, 32'd1);
    for (int m = 1; m < 16; m++) send(FN_FREE, 4'(m), 16'd1, 32'd4096 * 4095);
    live_handles.delete();

    // Random phases over several page sizes, extremes included
    sizes = '{16'd1, 16'd65535, 16'd0, 16'd512, 16'd4096};
    foreach (sizes[i]) begin
      set_page_size(sizes[i]);
      for (int j = 0; j < ((sizes[i] == 0) ? 20 : 55); j++) begin
        no_idle = (i == 3 && j >= 10 && j < 45);
        random_request();
      end
    end
    no_idle = 1'b0;

    // Let the last responses land
    while (pending != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    $display("Sent %0d requests over five page sizes; %0d responses compared.",
             sent, compared);
    $display("Covered bad sizes, too-long runs, all maps full, frees and queries.");
    if (fail_count == 0)
      $display("tb_contiguous_page_bitmap_allocator: clean");
    else
      $display("tb_contiguous_page_bitmap_allocator: errors");
    $finish;
  end

endmodule
